// File: design/arpc_pkg.sv
// shared types and codes of the arp resolver
package arpc_pkg;

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_RECV = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] FRAME_IPV4 = 2'd0;
  localparam logic [1:0] FRAME_ARP  = 2'd1;

  localparam logic [1:0] KIND_DELIVER = 2'd0;
  localparam logic [1:0] KIND_IPV4    = 2'd1;
  localparam logic [1:0] KIND_REQUEST = 2'd2;
  localparam logic [1:0] KIND_REPLY   = 2'd3;

  localparam logic [15:0] ARP_OPC_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OPC_REPLY   = 16'd2;

  localparam logic [1:0] REG_OWN_MAC  = 2'd0;
  localparam logic [1:0] REG_OWN_IP   = 2'd1;
  localparam logic [1:0] REG_RETRY    = 2'd2;
  localparam logic [1:0] REG_LIFETIME = 2'd3;

  localparam logic [15:0] RETRY_RESET    = 16'd5000;
  localparam logic [19:0] LIFETIME_RESET = 20'd30000;
  localparam logic [47:0] MAC_BROADCAST  = 48'hFFFF_FFFF_FFFF;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the input item
    logic clr;        // restart a scan
    logic cscan;      // one cache entry of search
    logic pscan;      // one pending entry of search
    logic tscan;      // one cache entry of expiry
    logic tick_now;   // advance time
    logic emit_fwd;   // ipv4 frame on cache hit
    logic emit_dlv;   // deliver received datagram
    logic send_fin;   // request, pending stamp and queue append
    logic learn;      // write cache, maybe answer
    logic fstep;      // one queue entry of flush
    logic fend;       // close flush, repack count
    logic finish;     // push staged result as last
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] op;
    logic       dlv_ok;
    logic       arp_ok;
    logic       hit;
    logic       c_last;
    logic       p_last;
    logic       q_end;
    logic       do_flush;
    logic       can_emit;
    logic       out_free;
    logic       stg_v;
  } sts_t;

endpackage

// File: design/arpc_ctrl.sv
// controller state machine of the arp resolver
module arpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  arpc_pkg::sts_t  sts,
  output arpc_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_CSCAN, S_CHIT, S_PSCAN, S_SFIN, S_LEARN, S_FLUSH, S_DRAIN, S_TSCAN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          arpc_pkg::OP_SEND: begin
            cmd.clr   = 1'b1;
            state_nxt = S_CSCAN;
          end
          arpc_pkg::OP_RECV: begin
            if (sts.dlv_ok) begin
              cmd.emit_dlv = 1'b1;
              state_nxt    = S_DRAIN;
            end else if (sts.arp_ok) begin
              cmd.clr   = 1'b1;
              state_nxt = S_CSCAN;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          arpc_pkg::OP_TICK: begin
            cmd.tick_now = 1'b1;
            cmd.clr      = 1'b1;
            state_nxt    = S_TSCAN;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_CSCAN: begin
        cmd.cscan = 1'b1;
        if (sts.c_last) begin
          state_nxt = (sts.op == arpc_pkg::OP_SEND) ? S_CHIT : S_LEARN;
        end
      end
      S_CHIT: begin
        if (sts.hit) begin
          cmd.emit_fwd = 1'b1;
          state_nxt    = S_DRAIN;
        end else begin
          cmd.clr   = 1'b1;
          state_nxt = S_PSCAN;
        end
      end
      S_PSCAN: begin
        cmd.pscan = 1'b1;
        if (sts.p_last) begin
          state_nxt = S_SFIN;
        end
      end
      S_SFIN: begin
        cmd.send_fin = 1'b1;
        state_nxt    = S_DRAIN;
      end
      S_LEARN: begin
        cmd.learn = 1'b1;
        if (sts.do_flush) begin
          cmd.clr   = 1'b1;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_FLUSH: begin
        if (sts.q_end) begin
          cmd.fend  = 1'b1;
          state_nxt = S_DRAIN;
        end else if (sts.can_emit) begin
          cmd.fstep = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts.stg_v) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_TSCAN: begin
        cmd.tscan = 1'b1;
        if (sts.c_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/arpc_dp.sv
// datapath of the arp resolver: tables, queue, scan unit and result registers
module arpc_dp #(
  parameter int CACHE_ENTRIES   = 16,
  parameter int PENDING_ENTRIES = 16,
  parameter int QUEUE_DEPTH     = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  arpc_pkg::cmd_t  cmd,
  output arpc_pkg::sts_t  sts,
  input  logic [1:0]      in_op,
  input  logic [31:0]     in_next_hop_ip,
  input  logic [15:0]     in_datagram_tag,
  input  logic [1:0]      in_frame_kind,
  input  logic [47:0]     in_frame_dst_mac,
  input  logic            in_payload_ok,
  input  logic [15:0]     in_arp_opcode,
  input  logic [31:0]     in_arp_sender_ip,
  input  logic [47:0]     in_arp_sender_mac,
  input  logic [31:0]     in_arp_target_ip,
  input  logic [47:0]     in_arp_target_mac,
  input  logic [15:0]     in_elapsed_ms,
  input  logic            cfg_valid,
  input  logic [1:0]      cfg_index,
  input  logic [47:0]     cfg_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_kind,
  output logic [47:0]     out_dst_mac,
  output logic [15:0]     out_tag,
  output logic [31:0]     out_target_ip,
  output logic [47:0]     out_target_mac,
  output logic            out_last
);

  localparam int CIW  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PIW  = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int QIW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int MAXN = (CACHE_ENTRIES > PENDING_ENTRIES) ?
                        ((CACHE_ENTRIES > QUEUE_DEPTH) ? CACHE_ENTRIES : QUEUE_DEPTH) :
                        ((PENDING_ENTRIES > QUEUE_DEPTH) ? PENDING_ENTRIES : QUEUE_DEPTH);
  localparam int IW   = $clog2(MAXN + 1);

  // configuration
  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;
  logic [15:0] retry_r;
  logic [19:0] life_r;

  // captured item
  logic [1:0]  op_r;
  logic [31:0] hop_r;
  logic [15:0] tag_r;
  logic [1:0]  kind_r;
  logic [47:0] fdst_r;
  logic        ok_r;
  logic [15:0] opc_r;
  logic [31:0] sip_r;
  logic [47:0] smac_r;
  logic [31:0] tip_r;
  logic [47:0] tmac_r;
  logic [15:0] elapsed_r;

  logic [31:0] now_r;

  // tables
  logic        c_val_r   [CACHE_ENTRIES];
  logic [31:0] c_ip_r    [CACHE_ENTRIES];
  logic [47:0] c_mac_r   [CACHE_ENTRIES];
  logic [31:0] c_stamp_r [CACHE_ENTRIES];
  logic        p_val_r   [PENDING_ENTRIES];
  logic [31:0] p_ip_r    [PENDING_ENTRIES];
  logic [31:0] p_stamp_r [PENDING_ENTRIES];
  logic [31:0] q_ip_r    [QUEUE_DEPTH];
  logic [15:0] q_tag_r   [QUEUE_DEPTH];
  logic [QCW-1:0] q_cnt_r;

  // scan state
  logic [IW-1:0]  idx_r;
  logic [QCW-1:0] k_r;
  logic           m_found_r, f_found_r;
  logic [IW-1:0]  m_idx_r, f_idx_r, b_idx_r;
  logic [31:0]    m_age_r, b_age_r;
  logic [47:0]    m_mac_r;

  // staged result and output register
  logic        stg_v_r;
  logic [1:0]  stg_kind_r;
  logic [47:0] stg_mac_r;
  logic [15:0] stg_tag_r;
  logic [31:0] stg_tip_r;
  logic [47:0] stg_tmac_r;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [47:0] out_dst_mac_r;
  logic [15:0] out_tag_r;
  logic [31:0] out_target_ip_r;
  logic [47:0] out_target_mac_r;
  logic        out_last_r;

  logic [CIW-1:0] ci;
  logic [PIW-1:0] pi;
  logic [QIW-1:0] qj, qk;
  logic [IW-1:0]  slot;
  logic [31:0]    key, e_ip, e_stamp, age;
  logic           e_val, e_match;
  logic           pend_fresh, reply_cond, out_free, can_emit;
  logic           emit;
  logic [1:0]     e_kind;
  logic [47:0]    e_mac, e_tmac;
  logic [15:0]    e_tag;
  logic [31:0]    e_tip;
  logic           q_hit;

  assign ci = idx_r[CIW-1:0];
  assign pi = idx_r[PIW-1:0];
  assign qj = idx_r[QIW-1:0];
  assign qk = k_r[QIW-1:0];

  assign key     = (op_r == arpc_pkg::OP_SEND) ? hop_r : sip_r;
  assign e_val   = cmd.pscan ? p_val_r[pi] : c_val_r[ci];
  assign e_ip    = cmd.pscan ? p_ip_r[pi] : c_ip_r[ci];
  assign e_stamp = cmd.pscan ? p_stamp_r[pi] : c_stamp_r[ci];
  assign age     = now_r - e_stamp;
  assign e_match = e_val && (e_ip == key);

  assign slot = m_found_r ? m_idx_r : (f_found_r ? f_idx_r : b_idx_r);

  assign pend_fresh = m_found_r && (m_age_r <= {16'd0, retry_r});
  assign reply_cond = (tip_r == own_ip_r) && (opc_r == arpc_pkg::ARP_OPC_REQUEST);
  assign q_hit      = (q_ip_r[qj] == sip_r);

  assign out_free = !out_valid_r || out_ready;
  assign can_emit = !stg_v_r || out_free;

  // result selection
  always_comb begin
    emit   = 1'b0;
    e_kind = arpc_pkg::KIND_DELIVER;
    e_mac  = '0;
    e_tag  = '0;
    e_tip  = '0;
    e_tmac = '0;
    if (cmd.emit_fwd) begin
      emit   = 1'b1;
      e_kind = arpc_pkg::KIND_IPV4;
      e_mac  = m_mac_r;
      e_tag  = tag_r;
    end else if (cmd.emit_dlv) begin
      emit   = 1'b1;
      e_kind = arpc_pkg::KIND_DELIVER;
      e_tag  = tag_r;
    end else if (cmd.send_fin && !pend_fresh) begin
      emit   = 1'b1;
      e_kind = arpc_pkg::KIND_REQUEST;
      e_mac  = arpc_pkg::MAC_BROADCAST;
      e_tip  = hop_r;
    end else if (cmd.learn && reply_cond) begin
      emit   = 1'b1;
      e_kind = arpc_pkg::KIND_REPLY;
      e_mac  = smac_r;
      e_tip  = sip_r;
      e_tmac = smac_r;
    end else if (cmd.fstep && q_hit) begin
      emit   = 1'b1;
      e_kind = arpc_pkg::KIND_IPV4;
      e_mac  = smac_r;
      e_tag  = q_tag_r[qj];
    end
  end

  always_comb begin
    sts.op       = op_r;
    sts.dlv_ok   = (kind_r == arpc_pkg::FRAME_IPV4) && (fdst_r == own_mac_r) && ok_r;
    sts.arp_ok   = (kind_r == arpc_pkg::FRAME_ARP) && ok_r;
    sts.hit      = m_found_r;
    sts.c_last   = (idx_r == IW'(CACHE_ENTRIES - 1));
    sts.p_last   = (idx_r == IW'(PENDING_ENTRIES - 1));
    sts.q_end    = (idx_r == IW'(q_cnt_r));
    sts.do_flush = (tmac_r == own_mac_r) && (opc_r == arpc_pkg::ARP_OPC_REPLY);
    sts.can_emit = can_emit;
    sts.out_free = out_free;
    sts.stg_v    = stg_v_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r   <= '0;
      own_ip_r    <= '0;
      retry_r     <= arpc_pkg::RETRY_RESET;
      life_r      <= arpc_pkg::LIFETIME_RESET;
      now_r       <= '0;
      q_cnt_r     <= '0;
      stg_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CACHE_ENTRIES; i++) c_val_r[i] <= 1'b0;
      for (int i = 0; i < PENDING_ENTRIES; i++) p_val_r[i] <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          arpc_pkg::REG_OWN_MAC:  own_mac_r <= cfg_data;
          arpc_pkg::REG_OWN_IP:   own_ip_r  <= cfg_data[31:0];
          arpc_pkg::REG_RETRY:    retry_r   <= cfg_data[15:0];
          arpc_pkg::REG_LIFETIME: life_r    <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (cmd.tick_now) now_r <= now_r + {16'd0, elapsed_r};
      if (cmd.tscan && c_val_r[ci] && (age > {12'd0, life_r})) c_val_r[ci] <= 1'b0;
      if (cmd.learn) c_val_r[slot[CIW-1:0]] <= 1'b1;
      if (cmd.send_fin && !pend_fresh) begin
        p_val_r[slot[PIW-1:0]] <= 1'b1;
        if (q_cnt_r != QCW'(QUEUE_DEPTH)) q_cnt_r <= q_cnt_r + 1'b1;
      end
      if (cmd.fend) q_cnt_r <= k_r;

      // output register
      if (cmd.finish || (emit && stg_v_r)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.finish) stg_v_r <= 1'b0;
      if (emit) stg_v_r <= 1'b1;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      hop_r     <= in_next_hop_ip;
      tag_r     <= in_datagram_tag;
      kind_r    <= in_frame_kind;
      fdst_r    <= in_frame_dst_mac;
      ok_r      <= in_payload_ok;
      opc_r     <= in_arp_opcode;
      sip_r     <= in_arp_sender_ip;
      smac_r    <= in_arp_sender_mac;
      tip_r     <= in_arp_target_ip;
      tmac_r    <= in_arp_target_mac;
      elapsed_r <= in_elapsed_ms;
    end

    // search over one table entry per cycle
    if (cmd.cscan || cmd.pscan) begin
      if (e_match && !m_found_r) begin
        m_found_r <= 1'b1;
        m_idx_r   <= idx_r;
        m_age_r   <= age;
        m_mac_r   <= c_mac_r[ci];
      end
      if (!e_val && !f_found_r) begin
        f_found_r <= 1'b1;
        f_idx_r   <= idx_r;
      end
      if ((idx_r == '0) || (age > b_age_r)) begin
        b_idx_r <= idx_r;
        b_age_r <= age;
      end
    end
    if (cmd.cscan || cmd.pscan || cmd.tscan || cmd.fstep) idx_r <= idx_r + 1'b1;
    if (cmd.clr) begin
      idx_r     <= '0;
      k_r       <= '0;
      m_found_r <= 1'b0;
      f_found_r <= 1'b0;
    end

    if (cmd.learn) begin
      c_ip_r[slot[CIW-1:0]]    <= sip_r;
      c_mac_r[slot[CIW-1:0]]   <= smac_r;
      c_stamp_r[slot[CIW-1:0]] <= now_r;
    end
    if (cmd.send_fin && !pend_fresh) begin
      p_ip_r[slot[PIW-1:0]]    <= hop_r;
      p_stamp_r[slot[PIW-1:0]] <= now_r;
      if (q_cnt_r != QCW'(QUEUE_DEPTH)) begin
        q_ip_r[q_cnt_r[QIW-1:0]]  <= hop_r;
        q_tag_r[q_cnt_r[QIW-1:0]] <= tag_r;
      end
    end
    // repack survivors toward the head
    if (cmd.fstep && !q_hit) begin
      q_ip_r[qk]  <= q_ip_r[qj];
      q_tag_r[qk] <= q_tag_r[qj];
      k_r         <= k_r + 1'b1;
    end

    if (emit) begin
      stg_kind_r <= e_kind;
      stg_mac_r  <= e_mac;
      stg_tag_r  <= e_tag;
      stg_tip_r  <= e_tip;
      stg_tmac_r <= e_tmac;
    end
    if (cmd.finish || (emit && stg_v_r)) begin
      out_kind_r       <= stg_kind_r;
      out_dst_mac_r    <= stg_mac_r;
      out_tag_r        <= stg_tag_r;
      out_target_ip_r  <= stg_tip_r;
      out_target_mac_r <= stg_tmac_r;
      out_last_r       <= cmd.finish;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_dst_mac    = out_dst_mac_r;
  assign out_tag        = out_tag_r;
  assign out_target_ip  = out_target_ip_r;
  assign out_target_mac = out_target_mac_r;
  assign out_last       = out_last_r;

endmodule

// File: design/arp_resolver_with_cache.sv
// top level of the arp resolver with address cache
// usage:
//   in_* is a valid/ready channel carrying one item: a datagram to send, a received
//   frame or a time tick. out_* is a valid/ready channel of result items; out_last
//   marks the final result caused by an input item. cfg_* writes one of four
//   registers (own mac, own ip, retry time, lifetime) by index; it is always ready,
//   and the user must write it only while the block is idle; it does not enforce this.
// sequence:
//   one item at a time. an item is captured and dispatched, then a search or expiry
//   scan steps over every cache entry, a cache miss also steps over every pending
//   entry, and a reply flush steps over every queued datagram, which waits while
//   the output is not free; then the item closes out. the single-ported scan over
//   the tables sets the length of an item.
// reset:
//   rst_n low clears time, all valid bits, the queue count and the registers to
//   their reset values; no clearing pass is needed.
// stall:
//   results pass through a stage register and an output register; while out_ready
//   is low the flush waits, and no new item is taken until all results
//   of the current one are delivered to the output register.
module arp_resolver_with_cache #(
  parameter int CACHE_ENTRIES   = 16,
  parameter int PENDING_ENTRIES = 16,
  parameter int QUEUE_DEPTH     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_next_hop_ip,
  input  logic [15:0] in_datagram_tag,
  input  logic [1:0]  in_frame_kind,
  input  logic [47:0] in_frame_dst_mac,
  input  logic        in_payload_ok,
  input  logic [15:0] in_arp_opcode,
  input  logic [31:0] in_arp_sender_ip,
  input  logic [47:0] in_arp_sender_mac,
  input  logic [31:0] in_arp_target_ip,
  input  logic [47:0] in_arp_target_mac,
  input  logic [15:0] in_elapsed_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [47:0] out_dst_mac,
  output logic [15:0] out_tag,
  output logic [31:0] out_target_ip,
  output logic [47:0] out_target_mac,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  arpc_pkg::cmd_t cmd;
  arpc_pkg::sts_t sts;

  // register writes are always accepted, without a stall
  assign cfg_ready = 1'b1;

  // sequencer: dispatch, scans, flush, drain
  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tables, scan unit and result registers
  arpc_dp #(
    .CACHE_ENTRIES   (CACHE_ENTRIES),
    .PENDING_ENTRIES (PENDING_ENTRIES),
    .QUEUE_DEPTH     (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_next_hop_ip    (in_next_hop_ip),
    .in_datagram_tag   (in_datagram_tag),
    .in_frame_kind     (in_frame_kind),
    .in_frame_dst_mac  (in_frame_dst_mac),
    .in_payload_ok     (in_payload_ok),
    .in_arp_opcode     (in_arp_opcode),
    .in_arp_sender_ip  (in_arp_sender_ip),
    .in_arp_sender_mac (in_arp_sender_mac),
    .in_arp_target_ip  (in_arp_target_ip),
    .in_arp_target_mac (in_arp_target_mac),
    .in_elapsed_ms     (in_elapsed_ms),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_dst_mac       (out_dst_mac),
    .out_tag           (out_tag),
    .out_target_ip     (out_target_ip),
    .out_target_mac    (out_target_mac),
    .out_last          (out_last)
  );

endmodule
